// ----- rtl/imuoma_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imuoma_pkg
// Types and constants shared by the offset-corrected moving average block.
// ----------------------------------------------------------------------------
package imuoma_pkg;

    localparam int NUM_CHANNELS = 10;
    localparam int CH_W         = 4;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_W        = 48;
    localparam int CFG_IDX_W    = 2;
    localparam int MAG_CH       = 3;

    // channel groups
    localparam logic [CH_W-1:0] CH_GYRO_FIRST = 4'd3;
    localparam logic [CH_W-1:0] CH_MAG_FIRST  = 4'd6;
    localparam logic [CH_W-1:0] CH_TEMP       = 4'd9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSETS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSETS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_OFFSETS   = 2'd2;

    localparam logic [CFG_W-1:0] MAG_OFFSET_RESET = 48'h00F4_FF91_002E;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
    } in_beat_t;

    typedef struct packed {
        logic [CH_W-1:0]            out_channel;
        logic signed [SAMPLE_W-1:0] average;
        logic signed [SAMPLE_W-1:0] mag_min;
        logic signed [SAMPLE_W-1:0] mag_max;
    } out_beat_t;

endpackage

`default_nettype wire

// ----- rtl/imu_offset_moving_average.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imu_offset_moving_average
// Ten-channel offset-corrected moving average with magnetometer min/max.
//
// Input beats carry a channel (0-2 accel, 3-5 gyro, 6-8 mag, 9 temperature)
// and a signed sample. The channel offset is subtracted with 16-bit wrap and
// the value replaces the oldest entry of that channel's window, held in one
// single-port RAM that is read and written in the cycle the beat is taken.
// Each beat on a valid channel gives one result beat: the window sum divided
// by WINDOW_LEN toward zero, plus the running mag min/max (zero otherwise).
// Beats on channels above 9 are dropped without a result.
// Throughput is one beat per cycle unless m_ready stalls; the pipeline stages are
// RAM read, sum update, two divider stages, min/max and output register.
// A stall on m_ready freezes the whole pipeline and holds s_ready low only
// while the output register is full and not being taken.
// Reset clears the sums, slot pointers, fill flags and min/max values and
// restores the default offsets; the window RAM is not cleared, since an
// old entry is only subtracted once its channel's window has filled.
// Offset registers are written through cfg_we / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
module imu_offset_moving_average
    import imuoma_pkg::*;
#(
    parameter int WINDOW_LEN = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_beat_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_beat_t                 m_data
);

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int DEPTH  = NUM_CHANNELS * WINDOW_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

    logic [CFG_W-1:0] accel_off_reg;
    logic [CFG_W-1:0] gyro_off_reg;
    logic [CFG_W-1:0] mag_off_reg;

    logic [SLOT_W-1:0]       slot_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] full_reg;
    logic signed [SUM_W-1:0] sum_reg [NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] min_reg [MAG_CH];
    logic signed [SAMPLE_W-1:0] max_reg [MAG_CH];

    logic en;
    logic accept;
    logic take;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_off_reg <= '0;
            gyro_off_reg  <= '0;
            mag_off_reg   <= MAG_OFFSET_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ACCEL_OFFSETS: accel_off_reg <= cfg_data;
                REG_GYRO_OFFSETS:  gyro_off_reg  <= cfg_data;
                REG_MAG_OFFSETS:   mag_off_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en     = !m_valid || m_ready;
    assign s_ready = en;
    assign accept = s_valid && en;
    assign take   = accept && (s_data.channel < CH_W'(NUM_CHANNELS));

    // offset lookup and write address
    logic [CFG_W-1:0]           grp_off;
    logic [1:0]                 sub;
    logic [SAMPLE_W-1:0]        offset;
    logic signed [SAMPLE_W-1:0] val0;
    logic [SLOT_W-1:0]          slot0;
    logic [SLOT_W-1:0]          slot_next;
    logic [ADDR_W-1:0]          addr0;

    always_comb begin
        grp_off = '0;
        sub     = 2'd0;
        if (s_data.channel < CH_GYRO_FIRST) begin
            grp_off = accel_off_reg;
            sub     = s_data.channel[1:0];
        end else if (s_data.channel < CH_MAG_FIRST) begin
            grp_off = gyro_off_reg;
            sub     = 2'(s_data.channel - CH_GYRO_FIRST);
        end else if (s_data.channel < CH_TEMP) begin
            grp_off = mag_off_reg;
            sub     = 2'(s_data.channel - CH_MAG_FIRST);
        end
        case (sub)
            2'd0:    offset = grp_off[15:0];
            2'd1:    offset = grp_off[31:16];
            2'd2:    offset = grp_off[47:32];
            default: offset = '0;
        endcase
        val0      = s_data.sample - $signed(offset);
        slot0     = slot_reg[s_data.channel];
        slot_next = (slot0 >= SLOT_LAST) ? '0 : slot0 + SLOT_W'(1);
        addr0     = ADDR_W'(s_data.channel * WINDOW_LEN) + ADDR_W'(slot0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                slot_reg[i] <= '0;
            end
        end else if (take) begin
            slot_reg[s_data.channel] <= slot_next;
            if (slot0 >= SLOT_LAST) begin
                full_reg[s_data.channel] <= 1'b1;
            end
        end
    end

    logic signed [SAMPLE_W-1:0] old_val;

    imuoma_window_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk   (aclk),
        .access (take),
        .addr   (addr0),
        .wdata  (val0),
        .rdata  (old_val)
    );

    // stage 1: sum update
    logic                       v1_reg;
    logic [CH_W-1:0]            ch1_reg;
    logic signed [SAMPLE_W-1:0] val1_reg;
    logic                       full1_reg;
    logic signed [SUM_W-1:0]    sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ch1_reg   <= s_data.channel;
            val1_reg  <= val0;
            full1_reg <= full_reg[s_data.channel];
        end
    end

    always_comb begin
        sum_next = sum_reg[ch1_reg] + SUM_W'(val1_reg)
                   - (full1_reg ? SUM_W'(old_val) : SUM_W'(0));
    end

    // stage 2: new sum into divider
    logic                    v2_reg;
    logic [CH_W-1:0]         ch2_reg;
    logic signed [SUM_W-1:0] sum2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (en) begin
            v2_reg <= v1_reg;
            if (v1_reg) begin
                sum_reg[ch1_reg] <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ch2_reg  <= ch1_reg;
            sum2_reg <= sum_next;
        end
    end

    // stages 3 and 4: divider
    logic signed [SAMPLE_W-1:0] avg4;
    logic                       v3_reg;
    logic                       v4_reg;
    logic [CH_W-1:0]            ch3_reg;
    logic [CH_W-1:0]            ch4_reg;

    imuoma_div_const #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_div (
        .aclk   (aclk),
        .en     (en),
        .sum_in (sum2_reg),
        .quot   (avg4)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ch3_reg <= ch2_reg;
            ch4_reg <= ch3_reg;
        end
    end

    // min/max tracking and output register
    logic                       is_mag;
    logic [1:0]                 mag_idx;
    logic signed [SAMPLE_W-1:0] min_next;
    logic signed [SAMPLE_W-1:0] max_next;
    logic                       m_valid_reg;
    out_beat_t                  m_data_reg;

    always_comb begin
        is_mag   = (ch4_reg >= CH_MAG_FIRST) && (ch4_reg < CH_TEMP);
        mag_idx  = 2'(ch4_reg - CH_MAG_FIRST);
        min_next = '0;
        max_next = '0;
        if (is_mag) begin
            min_next = (avg4 < min_reg[mag_idx]) ? avg4 : min_reg[mag_idx];
            max_next = (avg4 > max_reg[mag_idx]) ? avg4 : max_reg[mag_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAG_CH; i++) begin
                min_reg[i] <= '0;
                max_reg[i] <= '0;
            end
        end else if (en) begin
            m_valid_reg <= v4_reg;
            if (v4_reg && is_mag) begin
                min_reg[mag_idx] <= min_next;
                max_reg[mag_idx] <= max_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.out_channel <= ch4_reg;
            m_data_reg.average     <= avg4;
            m_data_reg.mag_min     <= min_next;
            m_data_reg.mag_max     <= max_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- rtl/imuoma_window_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imuoma_window_ram
// Window sample store: single port, read-before-write, registered read data.
// ----------------------------------------------------------------------------
module imuoma_window_ram
    import imuoma_pkg::*;
#(
    parameter int DEPTH  = 100,
    parameter int ADDR_W = 7
) (
    input  wire logic                       aclk,
    input  wire logic                       access,
    input  wire logic [ADDR_W-1:0]          addr,
    input  wire logic signed [SAMPLE_W-1:0] wdata,
    output logic signed [SAMPLE_W-1:0]      rdata
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (access) begin
            rdata_reg <= mem[addr];
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/imuoma_div_const.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imuoma_div_const
// Two-stage signed division of the window sum by the window length,
// truncated toward zero, by reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module imuoma_div_const
    import imuoma_pkg::*;
#(
    parameter int WINDOW_LEN = 10,
    parameter int SUM_W      = 20
) (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic signed [SUM_W-1:0]    sum_in,
    output logic signed [SAMPLE_W-1:0]      quot
);

    localparam longint unsigned RECIP = (64'd1 << SUM_W) / WINDOW_LEN;
    localparam logic [SUM_W-1:0] RECIP_C = RECIP[SUM_W-1:0];
    localparam logic [SUM_W-1:0] LEN_C   = SUM_W'(WINDOW_LEN);

    logic [SUM_W-1:0]   abs_val;
    logic [SUM_W-1:0]   abs_reg;
    logic               neg_reg;
    logic [2*SUM_W-1:0] prod_reg;
    logic [SUM_W-1:0]   q_est;
    logic [SUM_W-1:0]   rem;
    logic [SUM_W-1:0]   q_fix;
    logic [SUM_W-1:0]   q_signed;
    logic signed [SAMPLE_W-1:0] quot_reg;

    assign abs_val = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);

    always_ff @(posedge aclk) begin
        if (en) begin
            abs_reg  <= abs_val;
            neg_reg  <= sum_in[SUM_W-1];
            prod_reg <= abs_val * RECIP_C;
        end
    end

    // estimate is low by at most one
    always_comb begin
        q_est    = prod_reg[2*SUM_W-1:SUM_W];
        rem      = abs_reg - SUM_W'(q_est * LEN_C);
        q_fix    = (rem >= LEN_C) ? q_est + SUM_W'(1) : q_est;
        q_signed = neg_reg ? SUM_W'(-q_fix) : q_fix;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= q_signed[SAMPLE_W-1:0];
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire
